### src/rrts_pkg.sv
package rrts_pkg;

    // Sizing
    localparam int MAX_TASKS = 16;
    localparam int NUM_SEMAPHORES = 4;
    localparam int TASK_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int SEM_W = $clog2(NUM_SEMAPHORES);

    // Request codes
    localparam logic [2:0] REQ_RUN = 3'd0;
    localparam logic [2:0] REQ_TICK = 3'd1;
    localparam logic [2:0] REQ_YIELD = 3'd2;
    localparam logic [2:0] REQ_DELAY = 3'd3;
    localparam logic [2:0] REQ_EXIT = 3'd4;
    localparam logic [2:0] REQ_PEND = 3'd5;
    localparam logic [2:0] REQ_POST = 3'd6;
    // Unused code, behaves as run
    localparam logic [2:0] REQ_SPARE = 3'd7;

    // Task status codes
    localparam logic [1:0] TS_READY = 2'd0;
    localparam logic [1:0] TS_SEMWAIT = 2'd1;
    localparam logic [1:0] TS_EXITED = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_NTASKS = 3'd0;
    localparam logic [2:0] CFG_SEM0 = 3'd1;
    localparam logic [2:0] CFG_SEM3 = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] delay_ticks;
        logic [1:0]  sem_id;
    } t_req;

    typedef struct packed {
        logic [3:0] current_task;
        logic       switched;
        logic       caller_blocked;
        logic       woken_valid;
        logic [3:0] woken_task;
    } t_rsp;

    // One task table entry as held in the RAM
    typedef struct packed {
        logic [1:0]       status;
        logic [SEM_W-1:0] wsem;
        logic [15:0]      wait_cnt;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Ring size from the task count register, clamped to 1..MAX_TASKS
    function automatic logic [CNT_W-1:0] ring_size(input logic [4:0] tc);
        if (tc == 5'd0) begin
            return CNT_W'(1);
        end else if (int'(tc) > MAX_TASKS) begin
            return CNT_W'(MAX_TASKS);
        end else begin
            return CNT_W'(tc);
        end
    endfunction

    // Next task in ring order; tasks outside the ring go to the head
    function automatic logic [TASK_W-1:0] successor(input logic [TASK_W-1:0] t,
                                                    input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] head;
        head = n - CNT_W'(1);
        if (t == '0 || CNT_W'(t) >= n) begin
            return head[TASK_W-1:0];
        end else begin
            return t - TASK_W'(1);
        end
    endfunction

endpackage

### src/rrts_ram.sv
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/round_robin_task_scheduler_unit.sv
// Round-robin task scheduler with counting semaphores.
// Request channel: i_valid / o_stall carry one t_req (run, tick, yield,
// delay, exit, semaphore pend, semaphore post). Response channel: o_valid /
// i_stall carry one t_rsp per request: the task now running, whether it
// changed, whether a pend blocked the caller and which task a post woke.
// Configuration: i_cfg_we writes the number of tasks (index 0) or a semaphore's
// initial count (indexes 1 to 4, loading the count at once); the user must
// write it only while idle, which the block itself does not enforce. The
// task table sits in one RAM with a registered read; a request walks it
// once to update entries and once to find the next task. A yield, delay,
// exit or pend updates the running task's entry once scheduling has
// started; a tick walks all n ring entries and a post walks them until it
// wakes a task; the ring scan reads up to n entries (n the ring size).
// One request at a time; o_stall drops in the same cycle that o_valid rises.
// A response waits in an output register while i_stall is high; the next
// request is taken meanwhile and held in the last step until the register
// frees. Reset clears all tasks to ready with zero wait through per-entry
// valid bits, so no clearing pass is needed; the task count returns to 1.
module round_robin_task_scheduler_unit
    import rrts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_stall,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_state                    r_state, n_state;
    t_req                      r_req;
    logic [4:0]                r_tc;
    logic signed [7:0]         r_sem [NUM_SEMAPHORES];
    logic [TASK_W-1:0]         r_cur;
    logic                      r_started;
    logic [MAX_TASKS-1:0]      r_ent_vld;
    logic [CNT_W-1:0]          r_rlim;
    logic [CNT_W-1:0]          r_rcnt;
    logic [TASK_W-1:0]         r_ra;
    logic                      r_hit;
    logic [TASK_W-1:0]         r_next;
    logic                      r_pend_vld;
    logic [TASK_W-1:0]         r_pend_addr;
    logic                      r_pend_ev;
    logic                      r_blocked;
    logic                      r_woken;
    logic [TASK_W-1:0]         r_woken_id;
    logic                      r_ovalid;
    t_rsp                      r_orsp;

    logic [CNT_W-1:0]          ring_n;
    logic [CNT_W-1:0]          head_full;
    logic [TASK_W-1:0]         head;
    logic                      acc;
    logic                      pend_blk;
    logic [SEM_W-1:0]          sem_sel;
    logic signed [7:0]         sem_cur;
    logic                      rd_issue;
    logic [TASK_W-1:0]         rd_addr;
    logic [ENT_W-1:0]          rdata;
    t_entry                    ent;
    t_entry                    wr_ent;
    logic                      wr_en;
    logic                      upd_hit;
    logic                      scan_hit;
    logic                      upd_end;
    logic                      scan_more;
    logic                      scan_end;
    logic                      out_free;

    assign ring_n = ring_size(r_tc);
    assign head_full = ring_n - CNT_W'(1);
    assign head = head_full[TASK_W-1:0];
    assign acc = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign sem_sel = i_req.sem_id[SEM_W-1:0];
    assign sem_cur = r_sem[sem_sel];
    assign pend_blk = r_started && (i_req.req_type == REQ_PEND) && (sem_cur <= 8'sd0);

    // Task table
    rrts_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_TASKS)
    ) u_tab (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_pend_addr),
        .i_wdata(wr_ent),
        .i_raddr(rd_addr),
        .o_rdata(rdata)
    );

    // Entry never written reads as ready with zero wait
    assign ent = r_pend_ev ? t_entry'(rdata) : t_entry'('0);

    assign upd_hit = (r_state == ST_UPD) && r_pend_vld && !r_hit
                     && (r_req.req_type == REQ_POST) && (ent.status == TS_SEMWAIT)
                     && (ent.wsem == r_req.sem_id[SEM_W-1:0]);
    assign scan_hit = (r_state == ST_SCAN) && r_pend_vld && !r_hit
                      && (r_pend_addr != '0) && (ent.status == TS_READY)
                      && (ent.wait_cnt == 16'd0);
    assign upd_end = !r_pend_vld && (r_hit || (r_rcnt >= r_rlim));
    assign scan_more = (r_rcnt < r_rlim) && (r_ra != r_cur);
    assign scan_end = !r_pend_vld && (r_hit || !scan_more);

    // Entry modification for the returned read
    always_comb begin
        wr_ent = ent;
        case (r_req.req_type)
            REQ_TICK: begin
                if (ent.status == TS_READY && ent.wait_cnt != 16'd0) begin
                    wr_ent.wait_cnt = ent.wait_cnt - 16'd1;
                end
            end
            REQ_YIELD: begin
                if (ent.wait_cnt == 16'd0) begin
                    wr_ent.wait_cnt = 16'd1;
                end
            end
            REQ_DELAY: wr_ent.wait_cnt = r_req.delay_ticks;
            REQ_EXIT: wr_ent.status = TS_EXITED;
            REQ_PEND: begin
                if (r_blocked) begin
                    wr_ent.status = TS_SEMWAIT;
                    wr_ent.wsem = r_req.sem_id[SEM_W-1:0];
                end
            end
            REQ_POST: wr_ent.status = TS_READY;
            default: wr_ent = ent;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc) n_state = ST_UPD;
            end
            ST_UPD: begin
                if (upd_end) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: request stall, RAM read issue and write enable
    always_comb begin
        o_stall = 1'b1;
        rd_issue = 1'b0;
        wr_en = 1'b0;
        rd_addr = r_ra;
        case (r_state)
            ST_IDLE: o_stall = 1'b0;
            ST_UPD: begin
                rd_issue = (r_rcnt < r_rlim) && !r_hit && !upd_hit;
                wr_en = r_pend_vld && ((r_req.req_type != REQ_POST) || upd_hit);
            end
            ST_SCAN: rd_issue = scan_more && !r_hit && !scan_hit;
            ST_DONE: o_stall = 1'b1;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read pipeline tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            r_pend_vld <= rd_issue;
            if (wr_en) begin
                r_ent_vld[r_pend_addr] <= 1'b1;
            end
        end
        r_pend_addr <= rd_addr;
        r_pend_ev <= r_ent_vld[rd_addr];
    end

    // Sequencer: walk setup, counters, hits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0;
            r_rlim <= '0;
            r_hit <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_req <= i_req;
                        r_rcnt <= '0;
                        r_hit <= 1'b0;
                        r_blocked <= pend_blk;
                        r_woken <= 1'b0;
                        r_woken_id <= '0;
                        case (i_req.req_type)
                            REQ_TICK: begin
                                r_rlim <= ring_n;
                                r_ra <= '0;
                            end
                            REQ_POST: begin
                                r_rlim <= ring_n;
                                r_ra <= head;
                            end
                            REQ_YIELD, REQ_DELAY, REQ_EXIT, REQ_PEND: begin
                                r_rlim <= r_started ? CNT_W'(1) : '0;
                                r_ra <= r_cur;
                            end
                            default: begin
                                r_rlim <= '0;
                                r_ra <= r_cur;
                            end
                        endcase
                    end
                end
                ST_UPD: begin
                    if (rd_issue) begin
                        r_rcnt <= r_rcnt + CNT_W'(1);
                        if (r_req.req_type == REQ_TICK) begin
                            r_ra <= r_ra + TASK_W'(1);
                        end else if (r_req.req_type == REQ_POST) begin
                            r_ra <= r_ra - TASK_W'(1);
                        end
                    end
                    if (upd_hit) begin
                        r_hit <= 1'b1;
                        r_woken <= 1'b1;
                        r_woken_id <= r_pend_addr;
                    end
                    if (upd_end) begin
                        r_rcnt <= '0;
                        r_hit <= 1'b0;
                        r_rlim <= r_started ? ring_n : '0;
                        r_ra <= successor(r_cur, ring_n);
                    end
                end
                ST_SCAN: begin
                    if (rd_issue) begin
                        r_rcnt <= r_rcnt + CNT_W'(1);
                        r_ra <= successor(r_ra, ring_n);
                    end
                    if (scan_hit) begin
                        r_hit <= 1'b1;
                        r_next <= r_pend_addr;
                    end
                    if (scan_end) begin
                        if (!r_started) begin
                            r_next <= head;
                        end else if (!r_hit) begin
                            r_next <= '0;
                        end
                    end
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
    end

    // Configuration and semaphore counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= 5'd1;
            for (int s = 0; s < NUM_SEMAPHORES; s++) begin
                r_sem[s] <= 8'sd0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_NTASKS) begin
                r_tc <= i_cfg_data[4:0];
            end else if (i_cfg_idx inside {[CFG_SEM0:CFG_SEM3]}) begin
                r_sem[SEM_W'(i_cfg_idx - CFG_SEM0)] <= i_cfg_data;
            end
        end else if (acc) begin
            // saturate at -128 and 127
            if (i_req.req_type == REQ_PEND && r_started && sem_cur != 8'sh80) begin
                r_sem[sem_sel] <= sem_cur - 8'sd1;
            end else if (i_req.req_type == REQ_POST && sem_cur != 8'sh7F) begin
                r_sem[sem_sel] <= sem_cur + 8'sd1;
            end
        end
    end

    // Response register and running task
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_cur <= '0;
            r_started <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
                r_orsp.current_task <= 4'(r_next);
                r_orsp.switched <= !r_started || (r_next != r_cur);
                r_orsp.caller_blocked <= r_blocked;
                r_orsp.woken_valid <= r_woken;
                r_orsp.woken_task <= 4'(r_woken_id);
                r_cur <= r_next;
                r_started <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp = r_orsp;

    // Checks
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_issue) |-> (r_pend_addr != rd_addr))
        else $error("read and write of the same task entry in one cycle");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE))
        else $error("response raised outside the final step");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld)
        else $error("table read still in flight while idle");

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= CNT_W'(MAX_TASKS))
        else $error("walk counter beyond the table");

endmodule
